// ----- sv/segment_intersection_unit_assert.svh -----
// Assertion macros for the segment intersection unit.
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SIU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("siu assertion failed");
// Check that a condition is followed by another in the next cycle.
`define SIU_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) \
		else $error("siu assertion failed");
`else
`define SIU_ASSERT(lbl, prop)
`define SIU_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- sv/siu_pkg.sv -----
// Shared types and codes of the segment intersection unit.
package siu_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_NONE    = 2'd0;
	localparam kind_t KIND_PROPER  = 2'd1;
	localparam kind_t KIND_VERTEX  = 2'd2;
	localparam kind_t KIND_OVERLAP = 2'd3;

	// Per-request side data that rides along the divider chain.
	typedef struct packed {
		logic        par;
		kind_t       kind;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] ov_px;
		logic [31:0] ov_py;
		logic [31:0] ov_qx;
		logic [31:0] ov_qy;
	} side_t;

endpackage

// ----- sv/siu_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per request.
`include "segment_intersection_unit_assert.svh"

module siu_div_cell #(
	parameter int DW = 36,
	parameter int NW = 74
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [DW-1:0] in_den,
	input  logic [DW-1:0] in_rem,
	input  logic [NW-1:0] in_num,
	input  logic [NW-1:0] in_quo,
	output logic          out_vld,
	output logic [DW-1:0] out_den,
	output logic [DW-1:0] out_rem,
	output logic [NW-1:0] out_num,
	output logic [NW-1:0] out_quo
);

	logic [DW-1:0] trial;
	logic          ge;
	logic [DW-1:0] rem_n;
	logic          vld_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;

	// Shift in the next numerator bit and subtract when the divisor fits.
	always_comb begin
		trial = {in_rem[DW-2:0], in_num[NW-1]};
		ge    = (trial >= in_den);
		rem_n = ge ? (trial - in_den) : trial;
	end

	// Hold the request valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	// Advance the payload to the next cell.
	always_ff @(posedge clk) begin
		den_q <= in_den;
		rem_q <= rem_n;
		num_q <= {in_num[NW-2:0], 1'b0};
		quo_q <= {in_quo[NW-2:0], ge};
	end

	assign out_vld = vld_q;
	assign out_den = den_q;
	assign out_rem = rem_q;
	assign out_num = num_q;
	assign out_quo = quo_q;

	`SIU_ASSERT(a_rem_below_den, vld_q |-> rem_q < den_q)
	`SIU_ASSERT_NEXT(a_den_nonzero, in_vld, den_q != '0)

endmodule

// ----- sv/segment_intersection_unit.sv -----
// Top level of the segment intersection unit: geometry front end and divider chain.
//
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------
// request   | start, busy        | a_x a_y b_x b_y c_x c_y d_x d_y
// result    | done (one cycle)   | kind p_x p_y q_x q_y
//
// One request is taken every cycle; busy stays low.
// Quotient width NW = 3*COORD_BITS + 6 + FRAC_BITS (70 at defaults). Pipeline:
// five front-end stages, one divider cell per quotient bit, one output stage.
// Reset clears all valid flags; payload registers are not reset.
// The result is shown for one cycle with done and cannot be stalled.
`include "segment_intersection_unit_assert.svh"

module segment_intersection_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] d_x,
	input  logic signed [COORD_BITS-1:0] d_y,
	output logic                         done,
	output logic [1:0]                   kind,
	output logic signed [31:0]           p_x,
	output logic signed [31:0]           p_y,
	output logic signed [31:0]           q_x,
	output logic signed [31:0]           q_y
);

	localparam int C   = COORD_BITS;
	localparam int EW  = C + 1;
	localparam int PW  = 2 * C + 2;
	localparam int DW  = 2 * C + 4;
	localparam int XW  = C + DW + 2;
	localparam int NW  = XW + FRAC_BITS;
	localparam int SW  = (NW > 33) ? NW : 33;
	localparam int CW  = C + FRAC_BITS;
	localparam int CE  = (CW > 33) ? CW : 33;
	localparam int LAT = NW + 6;

	localparam logic signed [CE-1:0] CMAX = CE'(64'sh7FFF_FFFF);
	localparam logic signed [CE-1:0] CMIN = CE'(-64'sh8000_0000);
	localparam logic [SW-1:0] QMAXP = SW'(32'h7FFF_FFFF);
	localparam logic [SW-1:0] QMAXN = SW'(32'h8000_0000);

	// Betweenness of r on segment pq, on x or on y when pq is vertical.
	function automatic logic on_seg(
		input logic signed [C-1:0] px, input logic signed [C-1:0] py,
		input logic signed [C-1:0] qx, input logic signed [C-1:0] qy,
		input logic signed [C-1:0] rx, input logic signed [C-1:0] ry);
		logic signed [C-1:0] pk, qk, rk;
		begin
			pk = (px != qx) ? px : py;
			qk = (px != qx) ? qx : qy;
			rk = (px != qx) ? rx : ry;
			on_seg = (pk <= rk && rk <= qk) || (pk >= rk && rk >= qk);
		end
	endfunction

	// Scale a coordinate to fixed point and saturate to 32 bits.
	function automatic logic [31:0] fix_coord(input logic signed [C-1:0] v);
		logic signed [CE-1:0] w;
		begin
			w = CE'(v) <<< FRAC_BITS;
			if (w > CMAX)
				fix_coord = 32'h7FFF_FFFF;
			else if (w < CMIN)
				fix_coord = 32'h8000_0000;
			else
				fix_coord = w[31:0];
		end
	endfunction

	// Saturate a quotient magnitude with its sign to 32 bits.
	function automatic logic [31:0] sat_quo(input logic [NW-1:0] q, input logic neg);
		logic [SW-1:0] qe;
		logic [SW-1:0] qn;
		begin
			qe = SW'(q);
			qn = SW'(0) - qe;
			if (neg)
				sat_quo = (qe > QMAXN) ? 32'h8000_0000 : qn[31:0];
			else
				sat_quo = (qe > QMAXP) ? 32'h7FFF_FFFF : qe[31:0];
		end
	endfunction

	// Stage 1: register coordinates and their differences.
	logic                  vld_s1;
	logic signed [C-1:0]   ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;
	logic signed [EW-1:0]  d1c1_s1, c1d1_s1, b1a1_s1, a1b1_s1, a1d1_s1, c1a1_s1;
	logic signed [EW-1:0]  c1b1_s1, a1c1_s1, cb0_s1, ab0_s1, ba0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1   <= a_x;
		ay_s1   <= a_y;
		bx_s1   <= b_x;
		by_s1   <= b_y;
		cx_s1   <= c_x;
		cy_s1   <= c_y;
		dx_s1   <= d_x;
		dy_s1   <= d_y;
		d1c1_s1 <= EW'(d_y) - EW'(c_y);
		c1d1_s1 <= EW'(c_y) - EW'(d_y);
		b1a1_s1 <= EW'(b_y) - EW'(a_y);
		a1b1_s1 <= EW'(a_y) - EW'(b_y);
		a1d1_s1 <= EW'(a_y) - EW'(d_y);
		c1a1_s1 <= EW'(c_y) - EW'(a_y);
		c1b1_s1 <= EW'(c_y) - EW'(b_y);
		a1c1_s1 <= EW'(a_y) - EW'(c_y);
		cb0_s1  <= EW'(c_x) - EW'(b_x);
		ab0_s1  <= EW'(a_x) - EW'(b_x);
		ba0_s1  <= EW'(b_x) - EW'(a_x);
	end

	// Stage 2: form the cross products and the containment tests.
	logic                vld_s2;
	logic signed [C-1:0] ax_s2, ay_s2, bx_s2, by_s2, cx_s2, cy_s2, dx_s2, dy_s2;
	logic signed [EW-1:0] ba0_s2, ba1_s2;
	logic signed [PW-1:0] m_ad_s2, m_bc_s2, m_db_s2, m_ca_s2, m_cad_s2, m_dca_s2;
	logic signed [PW-1:0] m_acb_s2, m_bac_s2, m_cba_s2, m_ar1_s2, m_ar2_s2;
	logic                on_abc_s2, on_abd_s2, on_cda_s2, on_cdb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2     <= ax_s1;
		ay_s2     <= ay_s1;
		bx_s2     <= bx_s1;
		by_s2     <= by_s1;
		cx_s2     <= cx_s1;
		cy_s2     <= cy_s1;
		dx_s2     <= dx_s1;
		dy_s2     <= dy_s1;
		ba0_s2    <= ba0_s1;
		ba1_s2    <= b1a1_s1;
		m_ad_s2   <= PW'(ax_s1) * PW'(d1c1_s1);
		m_bc_s2   <= PW'(bx_s1) * PW'(c1d1_s1);
		m_db_s2   <= PW'(dx_s1) * PW'(b1a1_s1);
		m_ca_s2   <= PW'(cx_s1) * PW'(a1b1_s1);
		m_cad_s2  <= PW'(cx_s1) * PW'(a1d1_s1);
		m_dca_s2  <= PW'(dx_s1) * PW'(c1a1_s1);
		m_acb_s2  <= PW'(ax_s1) * PW'(c1b1_s1);
		m_bac_s2  <= PW'(bx_s1) * PW'(a1c1_s1);
		m_cba_s2  <= PW'(cx_s1) * PW'(b1a1_s1);
		m_ar1_s2  <= PW'(cb0_s1) * PW'(a1b1_s1);
		m_ar2_s2  <= PW'(ab0_s1) * PW'(c1b1_s1);
		on_abc_s2 <= on_seg(ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1);
		on_abd_s2 <= on_seg(ax_s1, ay_s1, bx_s1, by_s1, dx_s1, dy_s1);
		on_cda_s2 <= on_seg(cx_s1, cy_s1, dx_s1, dy_s1, ax_s1, ay_s1);
		on_cdb_s2 <= on_seg(cx_s1, cy_s1, dx_s1, dy_s1, bx_s1, by_s1);
	end

	// Stage 3: sum the products, normalize the sign, classify.
	logic signed [DW-1:0] den_c, ns_c, nt_c, area_c;
	logic signed [DW-1:0] den_n, ns_n, nt_n;
	logic                 par_c;
	siu_pkg::kind_t       kind_c;
	logic signed [C-1:0]  psx_c, psy_c, qsx_c, qsy_c;
	logic                 ovl_c;

	always_comb begin
		den_c  = DW'(m_ad_s2) + DW'(m_bc_s2) + DW'(m_db_s2) + DW'(m_ca_s2);
		ns_c   = DW'(m_ad_s2) + DW'(m_cad_s2) + DW'(m_dca_s2);
		nt_c   = DW'(0) - (DW'(m_acb_s2) + DW'(m_bac_s2) + DW'(m_cba_s2));
		area_c = DW'(m_ar1_s2) - DW'(m_ar2_s2);
		par_c  = (den_c == '0);
		den_n  = den_c;
		ns_n   = ns_c;
		nt_n   = nt_c;
		if (den_c < 0) begin
			den_n = DW'(0) - den_c;
			ns_n  = DW'(0) - ns_c;
			nt_n  = DW'(0) - nt_c;
		end
		// a parallel request still runs the divider; keep the divisor nonzero
		if (par_c) begin
			den_n = DW'(1);
		end
		ovl_c = 1'b1;
		psx_c = cx_s2;
		psy_c = cy_s2;
		qsx_c = dx_s2;
		qsy_c = dy_s2;
		if (on_abc_s2 && on_abd_s2) begin
			psx_c = cx_s2; psy_c = cy_s2; qsx_c = dx_s2; qsy_c = dy_s2;
		end else if (on_cda_s2 && on_cdb_s2) begin
			psx_c = ax_s2; psy_c = ay_s2; qsx_c = bx_s2; qsy_c = by_s2;
		end else if (on_abc_s2 && on_cdb_s2) begin
			psx_c = cx_s2; psy_c = cy_s2; qsx_c = bx_s2; qsy_c = by_s2;
		end else if (on_abc_s2 && on_cda_s2) begin
			psx_c = cx_s2; psy_c = cy_s2; qsx_c = ax_s2; qsy_c = ay_s2;
		end else if (on_abd_s2 && on_cdb_s2) begin
			psx_c = dx_s2; psy_c = dy_s2; qsx_c = bx_s2; qsy_c = by_s2;
		end else if (on_abd_s2 && on_cda_s2) begin
			psx_c = dx_s2; psy_c = dy_s2; qsx_c = ax_s2; qsy_c = ay_s2;
		end else begin
			ovl_c = 1'b0;
		end
		if (par_c) begin
			kind_c = (ovl_c && area_c == '0) ? siu_pkg::KIND_OVERLAP : siu_pkg::KIND_NONE;
		end else if (ns_n > 0 && ns_n < den_n && nt_n > 0 && nt_n < den_n) begin
			kind_c = siu_pkg::KIND_PROPER;
		end else if (ns_n < 0 || ns_n > den_n || nt_n < 0 || nt_n > den_n) begin
			kind_c = siu_pkg::KIND_NONE;
		end else begin
			kind_c = siu_pkg::KIND_VERTEX;
		end
	end

	logic                 vld_s3;
	logic signed [DW-1:0] den_s3, ns_s3;
	logic signed [C-1:0]  ax_s3, ay_s3;
	logic signed [EW-1:0] ba0_s3, ba1_s3;
	siu_pkg::side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s3        <= den_n;
		ns_s3         <= ns_n;
		ax_s3         <= ax_s2;
		ay_s3         <= ay_s2;
		ba0_s3        <= ba0_s2;
		ba1_s3        <= ba1_s2;
		side_s3.par   <= par_c;
		side_s3.kind  <= kind_c;
		side_s3.neg_x <= 1'b0;
		side_s3.neg_y <= 1'b0;
		if (kind_c == siu_pkg::KIND_OVERLAP) begin
			side_s3.ov_px <= fix_coord(psx_c);
			side_s3.ov_py <= fix_coord(psy_c);
			side_s3.ov_qx <= fix_coord(qsx_c);
			side_s3.ov_qy <= fix_coord(qsy_c);
		end else begin
			side_s3.ov_px <= '0;
			side_s3.ov_py <= '0;
			side_s3.ov_qx <= '0;
			side_s3.ov_qy <= '0;
		end
	end

	// Stage 4: point numerator products a*den and ns*(b-a).
	logic                 vld_s4;
	logic signed [XW-1:0] mx0_s4, mx1_s4, my0_s4, my1_s4;
	logic [DW-1:0]        den_s4;
	siu_pkg::side_t       side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		mx0_s4  <= XW'(ax_s3) * XW'(den_s3);
		mx1_s4  <= XW'(ns_s3) * XW'(ba0_s3);
		my0_s4  <= XW'(ay_s3) * XW'(den_s3);
		my1_s4  <= XW'(ns_s3) * XW'(ba1_s3);
		den_s4  <= den_s3;
		side_s4 <= side_s3;
	end

	// Stage 5: add, scale and split into sign and magnitude.
	logic signed [XW-1:0] sx_c, sy_c;
	logic signed [NW-1:0] shx_c, shy_c;
	siu_pkg::side_t       side_c;
	logic                 vld_s5;
	logic [NW-1:0]        numx_s5, numy_s5;
	logic [DW-1:0]        den_s5;
	siu_pkg::side_t       side_s5;

	always_comb begin
		sx_c         = mx0_s4 + mx1_s4;
		sy_c         = my0_s4 + my1_s4;
		shx_c        = NW'(sx_c) <<< FRAC_BITS;
		shy_c        = NW'(sy_c) <<< FRAC_BITS;
		side_c       = side_s4;
		side_c.neg_x = shx_c[NW-1];
		side_c.neg_y = shy_c[NW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		numx_s5 <= shx_c[NW-1] ? (NW'(0) - shx_c) : shx_c;
		numy_s5 <= shy_c[NW-1] ? (NW'(0) - shy_c) : shy_c;
		den_s5  <= den_s4;
		side_s5 <= side_c;
	end

	// Divider chains: one cell per quotient bit, x and y lanes side by side.
	logic          vx [NW+1];
	logic          vy [NW+1];
	logic [DW-1:0] dnx [NW+1];
	logic [DW-1:0] dny [NW+1];
	logic [DW-1:0] rmx [NW+1];
	logic [DW-1:0] rmy [NW+1];
	logic [NW-1:0] nmx [NW+1];
	logic [NW-1:0] nmy [NW+1];
	logic [NW-1:0] qux [NW+1];
	logic [NW-1:0] quy [NW+1];
	siu_pkg::side_t side_q [NW+1];

	assign vx[0]     = vld_s5;
	assign vy[0]     = vld_s5;
	assign dnx[0]    = den_s5;
	assign dny[0]    = den_s5;
	assign rmx[0]    = '0;
	assign rmy[0]    = '0;
	assign nmx[0]    = numx_s5;
	assign nmy[0]    = numy_s5;
	assign qux[0]    = '0;
	assign quy[0]    = '0;
	assign side_q[0] = side_s5;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		siu_div_cell #(.DW(DW), .NW(NW)) u_cell_x (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vx[k]),
			.in_den  (dnx[k]),
			.in_rem  (rmx[k]),
			.in_num  (nmx[k]),
			.in_quo  (qux[k]),
			.out_vld (vx[k+1]),
			.out_den (dnx[k+1]),
			.out_rem (rmx[k+1]),
			.out_num (nmx[k+1]),
			.out_quo (qux[k+1])
		);
		siu_div_cell #(.DW(DW), .NW(NW)) u_cell_y (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vy[k]),
			.in_den  (dny[k]),
			.in_rem  (rmy[k]),
			.in_num  (nmy[k]),
			.in_quo  (quy[k]),
			.out_vld (vy[k+1]),
			.out_den (dny[k+1]),
			.out_rem (rmy[k+1]),
			.out_num (nmy[k+1]),
			.out_quo (quy[k+1])
		);
		// Advance the side data beside the cells.
		always_ff @(posedge clk) begin
			side_q[k+1] <= side_q[k];
		end
	end

	// Output stage: saturate the quotient or take the overlap ends.
	logic           done_q;
	siu_pkg::kind_t kind_q;
	logic [31:0]    px_q, py_q, qx_q, qy_q;
	siu_pkg::side_t side_f;

	assign side_f = side_q[NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx[NW] && vy[NW];
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= side_f.kind;
		if (side_f.par) begin
			px_q <= side_f.ov_px;
			py_q <= side_f.ov_py;
			qx_q <= side_f.ov_qx;
			qy_q <= side_f.ov_qy;
		end else begin
			px_q <= sat_quo(qux[NW], side_f.neg_x);
			py_q <= sat_quo(quy[NW], side_f.neg_y);
			qx_q <= '0;
			qy_q <= '0;
		end
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign kind = kind_q;
	assign p_x  = px_q;
	assign p_y  = py_q;
	assign q_x  = qx_q;
	assign q_y  = qy_q;

	`SIU_ASSERT(a_fixed_latency, start |-> ##LAT done)
	`SIU_ASSERT(a_q_zero, done && kind != siu_pkg::KIND_OVERLAP |-> q_x == '0 && q_y == '0)

endmodule

// ----- dv/segment_intersection_unit_tb.sv -----
// Self-checking testbench of the segment intersection unit: directed table, then random pairs.
module segment_intersection_unit_tb;

	localparam int CB = 16;
	localparam int FB = 16;
	localparam int LATENCY = 3 * CB + 6 + FB + 6;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		siu_pkg::kind_t kind;
		logic [31:0]    px;
		logic [31:0]    py;
		logic [31:0]    qx;
		logic [31:0]    qy;
	} crossing_t;

	typedef struct {
		logic [15:0] c [8];
		bit          known;
		crossing_t   res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CB-1:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0;
	logic signed [CB-1:0] c_x = '0, c_y = '0, d_x = '0, d_y = '0;
	logic done;
	logic [1:0] kind;
	logic signed [31:0] p_x, p_y, q_x, q_y;

	crossing_t pending_crossings [$];
	int errors = 0;
	longint cycles = 0;
	int idle_pct = 0;

	segment_intersection_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
		.c_x(c_x), .c_y(c_y), .d_x(d_x), .d_y(d_y),
		.done(done), .kind(kind), .p_x(p_x), .p_y(p_y), .q_x(q_x), .q_y(q_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort on a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("segment_intersection_unit_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] sat_fix(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] scale_coord(input longint v);
		return sat_fix(v * (64'sd1 <<< FB));
	endfunction

	// Exact point coordinate base + num*diff/den in fixed point, truncated toward zero.
	function automatic logic [31:0] interp_fix(input longint base, input longint num,
			input longint diff, input longint den);
		logic signed [127:0] x, q;
		x = ((128'(base) * 128'(den)) + (128'(num) * 128'(diff))) <<< FB;
		q = x / 128'(den);
		if (q > 128'sd2147483647) return 32'h7FFFFFFF;
		if (q < -128'sd2147483648) return 32'h80000000;
		return q[31:0];
	endfunction

	function automatic bit between(input longint ax, ay, bx, by, px, py);
		longint ak, bk, pk;
		if (ax != bx) begin
			ak = ax; bk = bx; pk = px;
		end else begin
			ak = ay; bk = by; pk = py;
		end
		return (ak <= pk && pk <= bk) || (ak >= pk && pk >= bk);
	endfunction

	function automatic crossing_t classify(input logic [15:0] c [8]);
		crossing_t r;
		longint ax, ay, bx, by, cx, cy, dx, dy, den, ns, nt, area;
		bit ac, ad, ca, cb;
		ax = longint'($signed(c[0])); ay = longint'($signed(c[1]));
		bx = longint'($signed(c[2])); by = longint'($signed(c[3]));
		cx = longint'($signed(c[4])); cy = longint'($signed(c[5]));
		dx = longint'($signed(c[6])); dy = longint'($signed(c[7]));
		r = '{siu_pkg::KIND_NONE, 0, 0, 0, 0};
		den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
		if (den == 0) begin
			area = (cx - bx) * (ay - by) - (ax - bx) * (cy - by);
			if (area == 0) begin
				ac = between(ax, ay, bx, by, cx, cy);
				ad = between(ax, ay, bx, by, dx, dy);
				ca = between(cx, cy, dx, dy, ax, ay);
				cb = between(cx, cy, dx, dy, bx, by);
				r.kind = siu_pkg::KIND_OVERLAP;
				if (ac && ad) r = '{siu_pkg::KIND_OVERLAP, scale_coord(cx), scale_coord(cy),
					scale_coord(dx), scale_coord(dy)};
				else if (ca && cb) r = '{siu_pkg::KIND_OVERLAP, scale_coord(ax),
					scale_coord(ay), scale_coord(bx), scale_coord(by)};
				else if (ac && cb) r = '{siu_pkg::KIND_OVERLAP, scale_coord(cx),
					scale_coord(cy), scale_coord(bx), scale_coord(by)};
				else if (ac && ca) r = '{siu_pkg::KIND_OVERLAP, scale_coord(cx),
					scale_coord(cy), scale_coord(ax), scale_coord(ay)};
				else if (ad && cb) r = '{siu_pkg::KIND_OVERLAP, scale_coord(dx),
					scale_coord(dy), scale_coord(bx), scale_coord(by)};
				else if (ad && ca) r = '{siu_pkg::KIND_OVERLAP, scale_coord(dx),
					scale_coord(dy), scale_coord(ax), scale_coord(ay)};
				else r.kind = siu_pkg::KIND_NONE;
			end
		end else begin
			ns = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
			nt = -(ax * (cy - by) + bx * (ay - cy) + cx * (by - ay));
			if (den < 0) begin
				den = -den; ns = -ns; nt = -nt;
			end
			if (ns > 0 && ns < den && nt > 0 && nt < den) r.kind = siu_pkg::KIND_PROPER;
			else if (ns < 0 || ns > den || nt < 0 || nt > den) r.kind = siu_pkg::KIND_NONE;
			else r.kind = siu_pkg::KIND_VERTEX;
			r.px = interp_fix(ax, ns, bx - ax, den);
			r.py = interp_fix(ay, ns, by - ay, den);
		end
		return r;
	endfunction

	// Compare each done pulse against the oldest pending crossing.
	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && done) begin
			if (pending_crossings.size() == 0) begin
				$error("unexpected result kind=%0d", kind);
				errors++;
			end else begin
				e = pending_crossings.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d got %0d", e.kind, kind); errors++;
				end
				if (p_x !== e.px) begin
					$error("p_x: expected %h got %h", e.px, p_x); errors++;
				end
				if (p_y !== e.py) begin
					$error("p_y: expected %h got %h", e.py, p_y); errors++;
				end
				if (q_x !== e.qx) begin
					$error("q_x: expected %h got %h", e.qx, q_x); errors++;
				end
				if (q_y !== e.qy) begin
					$error("q_y: expected %h got %h", e.qy, q_y); errors++;
				end
			end
		end
	end

	// Present one request and hold it until it is taken.
	task automatic send_request(input logic [15:0] c [8], input crossing_t exp_res);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		a_x <= c[0]; a_y <= c[1]; b_x <= c[2]; b_y <= c[3];
		c_x <= c[4]; c_y <= c[5]; d_x <= c[6]; d_y <= c[7];
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_crossings.push_back(exp_res);
	endtask

	function automatic logic [15:0] rand_coord(input int mode);
		case (mode)
			0: return 16'($urandom_range(65535, 0));
			1: return 16'($signed($urandom_range(16, 0)) - 8);
			2: return ($urandom_range(1, 0)) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(400, 0)) - 200);
		endcase
	endfunction

	// Build a random segment pair: general, small grid, extreme values, collinear, or shared vertex.
	function automatic void rand_pair(output logic [15:0] c [8]);
		int shape, mode, k;
		longint bx, by, dx, dy, t0, t1;
		shape = $urandom_range(9, 0);
		mode = $urandom_range(3, 0);
		for (int i = 0; i < 8; i++) c[i] = rand_coord(mode);
		if (shape < 3) begin
			// collinear along a random small direction
			dx = $signed($urandom_range(6, 0)) - 3;
			dy = $signed($urandom_range(6, 0)) - 3;
			bx = $signed($urandom_range(200, 0)) - 100;
			by = $signed($urandom_range(200, 0)) - 100;
			for (int i = 0; i < 4; i++) begin
				k = $signed($urandom_range(20, 0)) - 10;
				c[2*i] = 16'(bx + k * dx);
				c[2*i+1] = 16'(by + k * dy);
			end
		end else if (shape == 3) begin
			k = $urandom_range(3, 0);
			t0 = $urandom_range(1, 0);
			t1 = 2 + $urandom_range(1, 0);
			c[2*t1] = c[2*t0];
			c[2*t1+1] = c[2*t0+1];
		end
	endfunction

	initial begin
		row_t rows [$];
		row_t r;
		logic [15:0] c [8];
		crossing_t none_res;
		none_res = '{siu_pkg::KIND_NONE, 0, 0, 0, 0};

		// Directed rows; known results only where obvious.
		r.known = 1'b0;
		r.c = '{16'd0, 16'd0, 16'd4, 16'd4, 16'd0, 16'd4, 16'd4, 16'd0}; rows.push_back(r);
		r.c = '{16'd0, 16'd0, 16'd4, 16'd0, 16'd4, 16'd0, 16'd4, 16'd4}; rows.push_back(r);
		r.c = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd5, 16'd0, 16'd6, 16'd9}; rows.push_back(r);
		r.c = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h8000}; rows.push_back(r);
		r.c = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h8001}; rows.push_back(r);
		r.c = '{16'd0, 16'd0, 16'd1, 16'd0, 16'h8000, 16'h7FFF, 16'h8001,
			16'h8000}; rows.push_back(r);
		r.known = 1'b1;
		// parallel, not collinear
		r.c = '{16'd0, 16'd0, 16'd4, 16'd0, 16'd0, 16'd1, 16'd4, 16'd1};
		r.res = none_res; rows.push_back(r);
		// collinear, disjoint
		r.c = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd3, 16'd0, 16'd5, 16'd0};
		r.res = none_res; rows.push_back(r);
		// cd inside ab
		r.c = '{16'd0, 16'd0, 16'd8, 16'd0, 16'd2, 16'd0, 16'd5, 16'd0};
		r.res = '{siu_pkg::KIND_OVERLAP, 32'h20000, 0, 32'h50000, 0}; rows.push_back(r);
		// ab inside cd, vertical
		r.c = '{16'd3, 16'd2, 16'd3, 16'd4, 16'd3, 16'd0, 16'd3, 16'd9};
		r.res = '{siu_pkg::KIND_OVERLAP, 32'h30000, 32'h20000, 32'h30000, 32'h40000};
		rows.push_back(r);
		// both points degenerate and equal at the extreme corner
		r.c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000};
		r.res = '{siu_pkg::KIND_OVERLAP, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000};
		rows.push_back(r);
		r.c = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF};
		r.res = '{siu_pkg::KIND_OVERLAP, 32'h7FFF0000, 32'h7FFF0000,
			32'h7FFF0000, 32'h7FFF0000};
		rows.push_back(r);
		// partial overlaps in each order
		r.known = 1'b0;
		r.c = '{16'd0, 16'd0, 16'd5, 16'd5, 16'd3, 16'd3, 16'd9, 16'd9}; rows.push_back(r);
		r.c = '{16'd0, 16'd0, 16'd5, 16'd5, 16'd3, 16'd3, 16'hFFFE, 16'hFFFE};
		rows.push_back(r);
		r.c = '{16'd5, 16'd5, 16'd0, 16'd0, 16'd9, 16'd9, 16'd3, 16'd3}; rows.push_back(r);
		r.c = '{16'd0, 16'd0, 16'd5, 16'd5, 16'hFFFE, 16'hFFFE, 16'd3, 16'd3};
		rows.push_back(r);
		// degenerate point on a segment
		r.c = '{16'd2, 16'd2, 16'd2, 16'd2, 16'd0, 16'd0, 16'd4, 16'd4}; rows.push_back(r);
		r.c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF}; rows.push_back(r);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (rows[i]) begin
			if (rows[i].known) send_request(rows[i].c, rows[i].res);
			else send_request(rows[i].c, classify(rows[i].c));
		end

		// Random pairs over several idling phases.
		for (int n = 0; n < 1500; n++) begin
			case ((n / 125) % 4)
				0: idle_pct = 0;
				1: idle_pct = 81;
				2: idle_pct = 0;
				default: idle_pct = 37;
			endcase
			rand_pair(c);
			send_request(c, classify(c));
		end
		start <= 1'b0;

		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("segment_intersection_unit_tb: PASS");
		end else begin
			$display("segment_intersection_unit_tb: FAIL");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+sv
sv/siu_pkg.sv
sv/siu_div_cell.sv
sv/segment_intersection_unit.sv
dv/segment_intersection_unit_tb.sv
